// ----- rtl/mf3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, register indexes, window types and the compare-exchange
// network used to find the median of a 3x3 pixel window.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W      = 8;
    localparam int LW_W       = 11;            // line_width register
    localparam int FH_W       = 12;            // frame_height register
    localparam int CFG_DATA_W = 12;            // widest register
    localparam int COL_W      = 10;            // column position
    localparam int LINE_DEPTH = 1024;          // longest line
    localparam int WIN_ROWS   = 3;
    localparam int WIN_COLS   = 3;
    localparam int WIN_SIZE   = WIN_ROWS * WIN_COLS;
    localparam int MEDIAN_IDX = WIN_SIZE / 2;

    localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam logic [LW_W-1:0] LW_MIN   = LW_W'(WIN_COLS);
    localparam logic [LW_W-1:0] LW_MAX   = LW_W'(LINE_DEPTH);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(WIN_ROWS);

    // Configuration register indexes.
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]          pixel_t;
    typedef pixel_t [WIN_SIZE-1:0]     win_t;
    typedef logic [3:0]                wsel_t;

    // First half of the median network: sort each row of three.
    localparam int    PRE_OPS = 9;
    localparam wsel_t PRE_LO [PRE_OPS] = '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6,
                                           4'd1, 4'd4, 4'd7};
    localparam wsel_t PRE_HI [PRE_OPS] = '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7,
                                           4'd2, 4'd5, 4'd8};

    // Second half: merge the sorted rows down to the middle element.
    localparam int    FIN_OPS = 10;
    localparam wsel_t FIN_LO [FIN_OPS] = '{4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2,
                                           4'd4, 4'd4, 4'd6, 4'd4};
    localparam wsel_t FIN_HI [FIN_OPS] = '{4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5,
                                           4'd7, 4'd2, 4'd4, 4'd2};

    // After each step the element at lo holds the smaller value.
    function automatic win_t median_presort(input win_t w);
        win_t   v;
        pixel_t t;
        v = w;
        for (int k = 0; k < PRE_OPS; k++) begin
            if (v[PRE_LO[k]] > v[PRE_HI[k]]) begin
                t            = v[PRE_LO[k]];
                v[PRE_LO[k]] = v[PRE_HI[k]];
                v[PRE_HI[k]] = t;
            end
        end
        return v;
    endfunction

    function automatic pixel_t median_finish(input win_t w);
        win_t   v;
        pixel_t t;
        v = w;
        for (int k = 0; k < FIN_OPS; k++) begin
            if (v[FIN_LO[k]] > v[FIN_HI[k]]) begin
                t            = v[FIN_LO[k]];
                v[FIN_LO[k]] = v[FIN_HI[k]];
                v[FIN_HI[k]] = t;
            end
        end
        return v[MEDIAN_IDX];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/median_filter_3x3_gray.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_gray
// Streaming 3x3 median filter for 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                   Handshake
//  -------   ---------  --------------------------------------  ---------------
//  input     in         s_pixel, s_frame_start                  s_valid/s_ready
//  result    out        m_median_value, m_frame_done            m_valid/m_ready
//  config    in         cfg_index, cfg_wr_data                  cfg_wr_en
//
// The block takes one item per clock while the skid register is empty. An
// accepted item goes through position and line buffer read, window shift
// and line buffer write, row presort and median merge, in that order, and
// its result then leaves the last pipeline stage. The line memory takes one
// read, at the new item's column, and one write, at the previous item's
// column, in the same cycle, so a new item can enter on every clock while the skid register is empty.
// Reset (aresetn low, synchronous) returns the position to row 0, column 0,
// loads the default size of 640 x 480 and empties the pipeline; the line
// memory and the window are not cleared.
// When the result side stalls, a skid register catches one more result and
// s_ready then drops until the result ahead of it is taken.
// ----------------------------------------------------------------------------
module median_filter_3x3_gray
    import mf3_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel,
    input  wire logic                  s_frame_start,

    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [PIX_W-1:0]      m_median_value,
    output      logic                  m_frame_done,

    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [LW_W-1:0] line_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LW_RESET;
            frame_height_reg <= FH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wr_data[LW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range sizes are clamped to what the window and memory allow.
    logic [LW_W-1:0] eff_width;
    logic [FH_W-1:0] eff_height;

    always_comb begin
        if (line_width_reg < LW_MIN) begin
            eff_width = LW_MIN;
        end else if (line_width_reg > LW_MAX) begin
            eff_width = LW_MAX;
        end else begin
            eff_width = line_width_reg;
        end
        eff_height = (frame_height_reg < FH_MIN) ? FH_MIN : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipeline moves together; only a full
    // skid register holds it.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic advance;
    logic accept;

    assign advance = !skid_valid_reg;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage A: raster position of the accepted item.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] column_pos_reg, column_pos_next;
    logic [FH_W-1:0]  row_pos_reg, row_pos_next;

    logic [LW_W-1:0]  col_start, col_cur, col_inc;
    logic [FH_W-1:0]  row_start, row_cur, row_wrap, row_inc;
    logic [COL_W-1:0] item_col;
    logic             item_emit;
    logic             item_last;

    always_comb begin
        col_start = s_frame_start ? '0 : LW_W'(column_pos_reg);
        row_start = s_frame_start ? '0 : row_pos_reg;

        // A column past a shrunken width starts the next row.
        if (col_start >= eff_width) begin
            col_cur  = '0;
            row_wrap = row_start + FH_W'(1);
        end else begin
            col_cur  = col_start;
            row_wrap = row_start;
        end
        row_cur  = (row_wrap >= eff_height) ? '0 : row_wrap;
        item_col = col_cur[COL_W-1:0];

        // Results exist only once the window's bottom-right corner is in.
        item_emit = (row_cur >= FH_W'(WIN_ROWS - 1)) && (col_cur >= LW_W'(WIN_COLS - 1));
        item_last = (row_cur == eff_height - FH_W'(1)) && (col_cur == eff_width - LW_W'(1));

        col_inc = col_cur + LW_W'(1);
        if (col_inc >= eff_width) begin
            column_pos_next = '0;
            row_inc         = row_cur + FH_W'(1);
            row_pos_next    = (row_inc >= eff_height) ? '0 : row_inc;
        end else begin
            column_pos_next = col_inc[COL_W-1:0];
            row_inc         = row_cur;
            row_pos_next    = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
        end else if (accept) begin
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per column holds the two buffered lines,
    // the older line in the low byte. It is read when an item is accepted
    // and written back at the same column when the item moves on into
    // the window.
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
    logic [2*PIX_W-1:0] mem_rd_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_reg;
    logic [2*PIX_W-1:0] line_rd;
    logic [2*PIX_W-1:0] line_wr;
    logic               line_we;

    logic               p1_valid_reg;
    pixel_t             p1_pixel_reg;
    logic [COL_W-1:0]   p1_col_reg;
    logic               p1_emit_reg;
    logic               p1_last_reg;

    // A write still in flight to the column being read is forwarded.
    assign line_rd = byp_reg ? byp_data_reg : mem_rd_reg;
    assign line_we = advance && p1_valid_reg;
    assign line_wr = {p1_pixel_reg, line_rd[2*PIX_W-1:PIX_W]};

    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[p1_col_reg] <= line_wr;
        end
        if (accept) begin
            mem_rd_reg   <= line_mem[item_col];
            byp_data_reg <= line_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (accept) begin
            byp_reg <= line_we && (p1_col_reg == item_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pixel_reg <= s_pixel;
            p1_col_reg   <= item_col;
            p1_emit_reg  <= item_emit;
            p1_last_reg  <= item_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: shift a new column into the 3x3 window. Entry r*3+c is
    // row r (top first), column c (left first).
    // ------------------------------------------------------------------
    win_t window_reg;
    logic p2_valid_reg;
    logic p2_last_reg;

    always_ff @(posedge aclk) begin
        if (line_we) begin
            for (int r = 0; r < WIN_ROWS; r++) begin
                for (int c = 0; c < WIN_COLS - 1; c++) begin
                    window_reg[r*WIN_COLS + c] <= window_reg[r*WIN_COLS + c + 1];
                end
            end
            window_reg[WIN_COLS - 1]     <= line_rd[PIX_W-1:0];
            window_reg[2*WIN_COLS - 1]   <= line_rd[2*PIX_W-1:PIX_W];
            window_reg[WIN_SIZE - 1]     <= p1_pixel_reg;
            p2_last_reg                  <= p1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sort each window row.
    // ------------------------------------------------------------------
    win_t p3_vals_reg;
    logic p3_valid_reg;
    logic p3_last_reg;

    always_ff @(posedge aclk) begin
        if (advance && p2_valid_reg) begin
            p3_vals_reg <= median_presort(window_reg);
            p3_last_reg <= p2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (advance) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: merge to the median, into the output register or, when the
    // output is stalled, into the skid register.
    // ------------------------------------------------------------------
    pixel_t median_next;
    logic   out_valid_reg;
    pixel_t out_median_reg;
    logic   out_last_reg;
    pixel_t skid_median_reg;
    logic   skid_last_reg;
    logic   out_pop;

    assign median_next = median_finish(p3_vals_reg);
    assign out_pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (p3_valid_reg) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_median_reg <= skid_median_reg;
                out_last_reg   <= skid_last_reg;
            end
        end else if (p3_valid_reg) begin
            if (out_valid_reg && !m_ready) begin
                skid_median_reg <= median_next;
                skid_last_reg   <= p3_last_reg;
            end else begin
                out_median_reg <= median_next;
                out_last_reg   <= p3_last_reg;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_median_value = out_median_reg;
    assign m_frame_done   = out_last_reg;

endmodule
`default_nettype wire
